>>> design/ccs_pkg.sv
`default_nettype none

package ccs_pkg;

  // Field widths fixed by the interface
  localparam int LIT_W = 32;
  localparam int VAR_W = 31;
  localparam int TGT_W = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  // Default sizing
  localparam int MAX_LEN_DEF = 16;
  localparam int QDEPTH_DEF = 4;

  localparam logic [LIT_W-1:0] LIT_MAX = 32'h7FFF_FFFF;
  localparam logic [TGT_W-1:0] MIN_TARGET = 5'd3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_VARS   = 1'b0,
    CFG_TARGET_LEN = 1'b1
  } cfg_idx_t;

  // One buffered literal request
  typedef struct packed {
    logic [LIT_W-1:0] lit;
    logic             last;
  } ccs_item_t;

  // Live configuration as seen by the back end
  typedef struct packed {
    logic [VAR_W-1:0] num_vars;
    logic [TGT_W-1:0] tgt;
  } ccs_cfg_t;

  // Back-end sequencer
  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_CHK,
    S_RD_X,
    S_EM_X,
    S_RD_Y,
    S_EM_Y,
    S_EM_V,
    S_RD_O,
    S_EM_O
  } state_t;

endpackage

`default_nettype wire

>>> design/ccs_ram.sv
`default_nettype none

module ccs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/ccs_front.sv
`default_nettype none

module ccs_front #(
  parameter int DEPTH = ccs_pkg::QDEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [ccs_pkg::LIT_W-1:0] lit,
  input  logic                         last,
  output ccs_pkg::ccs_item_t           q_item,
  output logic                         q_valid,
  input  logic                         q_pop
);

  import ccs_pkg::*;

  localparam int PW = $clog2(DEPTH);

  ccs_item_t       qmem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  logic            push;
  logic            pop;

  assign in_stall = (count == (PW+1)'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = qmem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= '{lit: lit, last: last};
    end
  end

endmodule

`default_nettype wire

>>> design/ccs_back.sv
`default_nettype none

module ccs_back #(
  parameter int MAX_LEN = ccs_pkg::MAX_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ccs_pkg::ccs_cfg_t                cfg,
  input  ccs_pkg::ccs_item_t               q_item,
  input  logic                             q_valid,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [ccs_pkg::LIT_W-1:0] out_lit,
  output logic                             clause_end,
  output logic                             is_aux,
  output logic                             run_end,
  output logic                             error
);

  import ccs_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int EW = (CW > TGT_W) ? CW : TGT_W;
  localparam logic [CW-1:0] FULL = CW'(MAX_LEN);

  state_t           state;
  state_t           state_next;
  logic [CW-1:0]    fill;
  logic             overflow;
  logic [VAR_W-1:0] aux_used;
  logic [CW-1:0]    n;
  logic [CW-1:0]    idx;
  logic [CW-1:0]    splits;
  logic [CW-1:0]    desired;
  logic [LIT_W-1:0] sum;
  logic [LIT_W-1:0] vcur;
  logic             err;

  logic             slot_free;
  logic             buf_full;
  logic [CW-1:0]    fill_inc;
  logic [EW-1:0]    n_ext;
  logic [EW-1:0]    tgt_ext;
  logic [CW-1:0]    desired_c;
  logic             over;
  logic [CW-1:0]    avail;
  logic [CW-1:0]    splits_c;
  logic             last_orig;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [LIT_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [LIT_W-1:0] ram_rdata;

  logic             load;
  logic [LIT_W-1:0] load_lit;
  logic             load_end;
  logic             load_aux;
  logic             load_run;

  ccs_ram #(
    .WIDTH(LIT_W),
    .DEPTH(MAX_LEN)
  ) u_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign slot_free = !out_valid || !out_stall;
  assign buf_full  = (fill == FULL);
  assign fill_inc  = buf_full ? fill : fill + CW'(1);
  assign n_ext     = EW'(n);
  assign tgt_ext   = EW'(cfg.tgt);
  assign desired_c = (n_ext > tgt_ext) ? CW'(n_ext - tgt_ext) : '0;
  // aux range check: every wanted split needs a variable <= LIT_MAX;
  // a clause that needs no split never runs out
  assign over      = (desired != '0) &&
                     (({1'b0, sum} + (LIT_W+1)'(desired)) > {1'b0, LIT_MAX});
  assign avail     = (sum >= LIT_MAX) ? '0 : CW'(LIT_MAX - sum);
  assign splits_c  = over ? avail : desired;
  assign last_orig = (idx == n - CW'(1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_valid && q_item.last) begin
          state_next = S_PREP;
        end
      end
      S_PREP: state_next = S_CHK;
      S_CHK:  state_next = (splits_c != '0) ? S_RD_X : S_RD_O;
      S_RD_X: state_next = S_EM_X;
      S_EM_X: begin
        if (slot_free) begin
          state_next = S_RD_Y;
        end
      end
      S_RD_Y: state_next = S_EM_Y;
      S_EM_Y: begin
        if (slot_free) begin
          state_next = S_EM_V;
        end
      end
      S_EM_V: begin
        if (slot_free) begin
          state_next = (splits == CW'(1)) ? S_RD_O : S_RD_X;
        end
      end
      S_RD_O: state_next = S_EM_O;
      S_EM_O: begin
        if (slot_free) begin
          state_next = last_orig ? S_IDLE : S_RD_O;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = fill[AW-1:0];
    ram_wdata = q_item.lit;
    ram_raddr = idx[AW-1:0];
    load      = 1'b0;
    load_lit  = ram_rdata;
    load_end  = 1'b0;
    load_aux  = 1'b0;
    load_run  = 1'b0;
    case (state)
      S_IDLE: begin
        q_pop  = q_valid;
        ram_we = q_valid && !buf_full;
      end
      S_RD_X, S_EM_X: begin
        ram_raddr = AW'(n - CW'(1));
        load      = (state == S_EM_X) && slot_free;
        load_aux  = 1'b1;
      end
      S_RD_Y, S_EM_Y: begin
        ram_raddr = AW'(n - CW'(2));
        load      = (state == S_EM_Y) && slot_free;
        load_aux  = 1'b1;
      end
      S_EM_V: begin
        ram_we    = slot_free;
        ram_waddr = AW'(n - CW'(2));
        ram_wdata = vcur;
        load      = slot_free;
        load_lit  = LIT_W'(0) - vcur;
        load_end  = 1'b1;
        load_aux  = 1'b1;
      end
      S_EM_O: begin
        load     = slot_free;
        load_end = last_orig;
        load_run = last_orig;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      overflow  <= 1'b0;
      aux_used  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            fill <= fill_inc;
            if (buf_full) begin
              overflow <= 1'b1;
            end
          end
        end
        S_EM_V: begin
          if (slot_free) begin
            aux_used <= aux_used + VAR_W'(1);
          end
        end
        S_EM_O: begin
          if (slot_free && last_orig) begin
            fill     <= '0;
            overflow <= 1'b0;
          end
        end
        default: begin
          fill <= fill;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (load) begin
      out_lit    <= load_lit;
      clause_end <= load_end;
      is_aux     <= load_aux;
      run_end    <= load_run;
      error      <= err;
    end
    case (state)
      S_IDLE: begin
        if (q_valid && q_item.last) begin
          n <= fill_inc;
        end
      end
      S_PREP: begin
        sum     <= LIT_W'(cfg.num_vars) + LIT_W'(aux_used);
        desired <= desired_c;
      end
      S_CHK: begin
        splits <= splits_c;
        err    <= overflow | over;
        vcur   <= sum + LIT_W'(1);
        idx    <= '0;
      end
      S_EM_V: begin
        if (slot_free) begin
          n      <= n - CW'(1);
          vcur   <= vcur + LIT_W'(1);
          splits <= splits - CW'(1);
        end
      end
      S_EM_O: begin
        if (slot_free && !last_orig) begin
          idx <= idx + CW'(1);
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  // the last result of a clause is always the final original literal
  a_run_end_on_orig: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_end |-> clause_end && !is_aux)
    else $error("run_end on a result that does not close the shortened clause");

  // a split is never emitted without budget left
  a_split_budget: assert property (@(posedge clk) disable iff (rst)
    state == S_EM_V |-> splits != '0)
    else $error("split emitted with no split count left");

  // original-literal reads stay inside the shortened clause
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_O || state == S_EM_O) |-> idx < n && n <= FULL)
    else $error("original literal index outside the clause");

  // aux counter moves only when a new variable is handed out
  a_aux_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && aux_used != $past(aux_used) |->
      $past(state) == S_EM_V && $past(slot_free))
    else $error("aux counter changed outside a split");

endmodule

`default_nettype wire

>>> design/cnf_clause_splitter.sv
// CNF clause splitter. Literals of a clause arrive one request at a time on
// lit/last and are buffered (up to MAX_LEN per clause; more sets the error
// flag and is dropped). On the request marked last, the clause is cut from
// the back while longer than target_len: the last two literals x, y and a
// fresh variable v (num_vars+1, num_vars+2, ... counted since reset) give
// the clause {x, y, -v}, and v replaces x, y. Then the shortened original
// follows. Each result carries is_aux, clause_end, run_end (last result of
// that input clause) and error (buffer overflow or aux range exhausted, set
// on every result of the clause). A closing literal passes through the setup
// states S_PREP and S_CHK; then x, y and each original literal are read from
// the buffer RAM and then loaded into the output register, while -v is loaded
// straight from the variable counter; results are paced by the single read
// port of the clause buffer. A four-entry input queue keeps taking literals
// of the next clause while results drain. Configuration (cfg_index 0 =
// num_vars, 1 = target_len; target_len below 3 acts as 3) must be written
// only while the block is idle; the block does not enforce this, and
// cfg_ready is always high. No clearing pass is needed after reset.
`default_nettype none

module cnf_clause_splitter #(
  parameter int MAX_LEN     = ccs_pkg::MAX_LEN_DEF,
  parameter int QUEUE_DEPTH = ccs_pkg::QDEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ccs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ccs_pkg::CFG_DATA_W-1:0]        cfg_data,
  // literal input
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [ccs_pkg::LIT_W-1:0]      lit,
  input  logic                                  last,
  // result output
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [ccs_pkg::LIT_W-1:0]      out_lit,
  output logic                                  clause_end,
  output logic                                  is_aux,
  output logic                                  run_end,
  output logic                                  error
);

  import ccs_pkg::*;

  logic [VAR_W-1:0] num_vars;
  logic [TGT_W-1:0] target_len;
  ccs_cfg_t         cfg;
  ccs_item_t        q_item;
  logic             q_valid;
  logic             q_pop;

  // config writes are only legal while idle, so always take them
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_vars   <= '0;
      target_len <= MIN_TARGET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_VARS:   num_vars   <= cfg_data[VAR_W-1:0];
        CFG_TARGET_LEN: target_len <= cfg_data[TGT_W-1:0];
        default:        num_vars   <= num_vars;
      endcase
    end
  end

  // clamp target length to the 3-literal floor
  assign cfg.num_vars = num_vars;
  assign cfg.tgt      = (target_len < MIN_TARGET) ? MIN_TARGET : target_len;

  // front: input handshake and request queue
  ccs_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .lit     (lit),
    .last    (last),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  // back: clause buffer, splitting sequencer, output register
  ccs_back #(
    .MAX_LEN(MAX_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_lit   (out_lit),
    .clause_end(clause_end),
    .is_aux    (is_aux),
    .run_end   (run_end),
    .error     (error)
  );

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ccs_pkg::*;

  localparam int MAX_LEN = MAX_LEN_DEF;
  // Cycles allowed after the last result before touching config or ending:
  // up to four open literals may still sit in the input queue, plus setup.
  localparam int SETTLE_CYCLES = 30;

  // One result literal as the splitter should emit it
  typedef struct packed {
    logic signed [LIT_W-1:0] lit;
    logic                    clause_end;
    logic                    is_aux;
    logic                    run_end;
    logic                    error;
  } split_lit_t;

  // One literal request waiting to be driven
  typedef struct packed {
    logic [LIT_W-1:0] lit;
    logic             last;
  } lit_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [LIT_W-1:0] lit = '0;
  logic                    last = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [LIT_W-1:0] out_lit;
  logic                    clause_end;
  logic                    is_aux;
  logic                    run_end;
  logic                    error;

  cnf_clause_splitter u_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Splitter model state: live config plus the clause being collected.
  // ---------------------------------------------------------------------
  logic [VAR_W-1:0] m_nvars = '0;
  logic [TGT_W-1:0] m_tgt = MIN_TARGET;
  logic [LIT_W-1:0] m_buf [MAX_LEN];
  int               m_fill = 0;
  logic [VAR_W-1:0] m_aux = '0;     // aux variables handed out since reset
  logic             m_over = 1'b0;  // current clause lost literals

  split_lit_t expected_lits[$];
  lit_req_t   lit_queue[$];

  bit steady = 1'b0;   // phase with no gaps and no stalls
  bit lit_taken = 1'b0;
  int lit_gap = 0;
  int stall_left = 0;

  int mismatches = 0;
  int lits_sent = 0;
  int results_seen = 0;
  int clauses_split = 0;
  int clauses_flagged = 0;

  // Mostly back-to-back, often a short gap, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void note_lit(logic [LIT_W-1:0] l, logic ce, logic aux, logic re,
                                   logic er);
    split_lit_t item;
    item = '{lit: l, clause_end: ce, is_aux: aux, run_end: re, error: er};
    expected_lits = {expected_lits, item};
  endfunction

  // Buffer one literal; on the closing one, work out the whole burst of
  // split-off clauses and the shortened original.
  task automatic predict_splits(input logic [LIT_W-1:0] l, input logic lst);
    logic [TGT_W-1:0] tgt;
    logic [LIT_W-1:0] v;
    logic             err;
    longint           need, avail;
    int               n, s, i;
    if (m_fill < MAX_LEN) begin
      m_buf[m_fill] = l;
      m_fill++;
    end else begin
      m_over = 1'b1;   // buffer full: literal dropped
    end
    if (lst) begin
      tgt = (m_tgt < MIN_TARGET) ? MIN_TARGET : m_tgt;
      n = m_fill;
      need = (n > tgt) ? n - tgt : 0;
      // aux numbers left before passing the largest literal
      avail = longint'(LIT_MAX) - longint'(m_nvars) - longint'(m_aux);
      if (avail < 0) avail = 0;
      s = (need < avail) ? int'(need) : int'(avail);
      err = m_over || (s < need);
      for (i = 0; i < s; i++) begin
        v = LIT_W'(longint'(m_nvars) + longint'(m_aux) + 1);
        m_aux++;
        note_lit(m_buf[n-1], 1'b0, 1'b1, 1'b0, err);
        note_lit(m_buf[n-2], 1'b0, 1'b1, 1'b0, err);
        note_lit(-v, 1'b1, 1'b1, 1'b0, err);
        m_buf[n-2] = v;   // v takes the place of x and y
        n--;
      end
      for (i = 0; i < n; i++)
        note_lit(m_buf[i], i == n - 1, 1'b0, i == n - 1, err);
      if (s > 0) clauses_split++;
      if (err) clauses_flagged++;
      m_fill = 0;
      m_over = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------
  // Rising edge: check results first, then take requests and config writes.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_and_model
    split_lit_t want;
    if (rst) begin
      lit_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_lits.size() == 0) begin
          $error("result literal %0d arrived with nothing pending", out_lit);
          mismatches++;
        end else begin
          want = expected_lits.pop_front();
          if (out_lit !== want.lit) begin
            $error("out_lit: expected %0d, got %0d", want.lit, out_lit);
            mismatches++;
          end
          if (clause_end !== want.clause_end) begin
            $error("clause_end: expected %0b, got %0b", want.clause_end, clause_end);
            mismatches++;
          end
          if (is_aux !== want.is_aux) begin
            $error("is_aux: expected %0b, got %0b", want.is_aux, is_aux);
            mismatches++;
          end
          if (run_end !== want.run_end) begin
            $error("run_end: expected %0b, got %0b", want.run_end, run_end);
            mismatches++;
          end
          if (error !== want.error) begin
            $error("error: expected %0b, got %0b", want.error, error);
            mismatches++;
          end
        end
      end
      lit_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        lits_sent++;
        predict_splits(lit, last);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NUM_VARS:   m_nvars = cfg_data[VAR_W-1:0];
          CFG_TARGET_LEN: m_tgt = cfg_data[TGT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Literal driver: holds a request until taken, then the next one after a gap.
  always @(negedge clk) begin : drive_lits
    lit_req_t req;
    if (!rst && !(in_valid && !lit_taken)) begin
      if (lit_gap > 0) begin
        lit_gap--;
        in_valid <= 1'b0;
      end else if (lit_queue.size() > 0) begin
        req = lit_queue.pop_front();
        in_valid <= 1'b1;
        lit <= req.lit;
        last <= req.last;
        lit_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure, independent of out_valid.
  always @(negedge clk) begin : drive_stall
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap();
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk) cfg_valid = 1'b0;
  endtask

  // Unused upper data bits get random junk; the block must ignore them.
  task automatic set_config(input logic [VAR_W-1:0] nv, input logic [TGT_W-1:0] tg);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(CFG_NUM_VARS, {junk[31], nv});
    write_reg(CFG_TARGET_LEN, {junk[31:5], tg});
  endtask

  function automatic void push_lit(logic [LIT_W-1:0] l, logic lst);
    lit_req_t req;
    req = '{lit: l, last: lst};
    lit_queue = {lit_queue, req};
  endfunction

  // Random clause; literals lean toward the edges of the range.
  task automatic queue_clause(input int len);
    int               i, r;
    logic [LIT_W-1:0] l;
    for (i = 0; i < len; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) l = 32'h8000_0000;         // odd literal, most negative
      else if (r == 1) l = '0;               // odd literal, zero
      else if (r == 2) l = LIT_MAX;
      else if (r == 3) l = 32'h8000_0001;
      else if (r < 10) l = $urandom_range(0, 1) ? $urandom_range(1, 50)
                                                : -$urandom_range(1, 50);
      else l = $urandom();
      push_lit(l, i == len - 1);
    end
  endtask

  // Sender holds off until every pending result is out, then lets the block
  // finish any open literals before config changes.
  task automatic settle();
    while (lit_queue.size() != 0 || in_valid || expected_lits.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int               p, total, len, r, i;
    logic [VAR_W-1:0] nv;
    logic [TGT_W-1:0] tg;
    logic [LIT_W-1:0] room;

    repeat (10) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Directed: lone literal, then a five-literal clause with range extremes
    // and odd literals that needs two splits.
    set_config(31'd5, 5'd3);
    push_lit(32'd1, 1'b1);
    push_lit(LIT_MAX, 1'b0);
    push_lit(32'h8000_0001, 1'b0);
    push_lit(32'd0, 1'b0);
    push_lit(32'h8000_0000, 1'b0);
    push_lit(32'd7, 1'b1);
    settle();

    // Directed: one aux number left, target below three. A 17-literal clause
    // overflows the buffer and runs out of aux numbers; the next clause finds
    // the range already exhausted.
    room = LIT_MAX - 32'd1 - {1'b0, m_aux};
    set_config(room[VAR_W-1:0], 5'd0);
    for (i = 0; i < 17; i++)
      push_lit(i[0] ? -(i + 1) : i + 1, i == 16);
    queue_clause(4);
    settle();

    // Random phases, one setting each.
    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin nv = $urandom_range(0, 1000000); tg = 5'd3; end
        1: begin nv = '0; tg = 5'd16; end
        2: begin nv = $urandom_range(0, 32'h3FFF_FFFF); tg = $urandom_range(0, 31); end
        3: begin   // aux range runs dry partway through
          room = LIT_MAX - {1'b0, m_aux} - $urandom_range(4, 12);
          nv = room[VAR_W-1:0];
          tg = $urandom_range(3, 5);
        end
        4: begin nv = 31'h7FFF_FFFE; tg = 5'd2; end
        default: begin nv = $urandom_range(0, 1000); tg = 5'd31; end
      endcase
      set_config(nv, tg);
      steady = (p == 2);
      total = 0;
      while (total < 17) begin
        r = $urandom_range(0, 99);
        if (r < 65) len = $urandom_range(1, 6);
        else if (r < 88) len = $urandom_range(7, 16);
        else len = $urandom_range(17, 20);   // overflows the buffer
        queue_clause(len);
        total += len;
      end
      settle();
    end
    steady = 1'b0;

    $display("Sent %0d literal requests, checked %0d result literals.",
             lits_sent, results_seen);
    $display("%0d clauses were split, %0d carried the error flag, over eight settings.",
             clauses_split, clauses_flagged);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
